>>> design/ping_pong_buffer_controller_top_macros.svh
// assertion macros used by the checker file
`ifndef PING_PONG_BUFFER_CONTROLLER_TOP_MACROS_SVH
`define PING_PONG_BUFFER_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PPBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppbc check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define PPBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppbc check failed: next-cycle rule");

`endif

>>> design/ppbc_pkg.sv
// types and constants of the ping-pong buffer controller
`default_nettype none
package ppbc_pkg;

  // field widths
  localparam int unsigned PORT_W  = 2;
  localparam int unsigned LINE_W  = 9;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned BUF_W   = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned NBUF    = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned RIDX_W  = 3;

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DONE  = 1'b1;

  // engine port of the dsp side
  localparam logic [PORT_W-1:0] DSP_PORT = 2'd1;

  // register indexes
  localparam logic [RIDX_W-1:0] REG_NET_PORT  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_FWD_FIRST = 3'd1;
  localparam logic [RIDX_W-1:0] REG_FWD_LAST  = 3'd2;
  localparam logic [RIDX_W-1:0] REG_REV_FIRST = 3'd3;
  localparam logic [RIDX_W-1:0] REG_REV_LAST  = 3'd4;

  // register reset values
  localparam logic [PORT_W-1:0] NET_PORT_RST  = 2'd2;
  localparam logic [LINE_W-1:0] FWD_FIRST_RST = 9'd10;
  localparam logic [LINE_W-1:0] FWD_LAST_RST  = 9'd509;
  localparam logic [LINE_W-1:0] REV_FIRST_RST = 9'd5;
  localparam logic [LINE_W-1:0] REV_LAST_RST  = 9'd504;

  typedef enum logic [1:0] {
    PH_EMPTY     = 2'd0,
    PH_FILLING   = 2'd1,
    PH_FULL      = 2'd2,
    PH_EMPTYING  = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_SEND  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_START0 = 3'd1,
    BK_START1 = 3'd2,
    BK_CLR    = 3'd3,
    BK_RECV   = 3'd4,
    BK_SEND   = 3'd5
  } back_state_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [PORT_W-1:0] net_port;
    logic [LINE_W-1:0] fwd_first_line;
    logic [LINE_W-1:0] fwd_last_line;
    logic [LINE_W-1:0] rev_first_line;
    logic [LINE_W-1:0] rev_last_line;
  } cfg_t;

  // classified item in the queue
  typedef struct packed {
    logic              is_start;
    logic [MASK_W-1:0] mask;
  } item_t;

  // queue head toward the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // one buffer-manager command
  typedef struct packed {
    cmd_t              cmd_kind;
    logic [BUF_W-1:0]  buf_index;
    logic [PORT_W-1:0] port_sel;
    logic [LINE_W-1:0] first_line;
    logic [LINE_W-1:0] end_line;
    logic              last_cmd;
  } cmd_pay_t;

endpackage
`default_nettype wire

>>> design/ppbc_if.sv
// channel interfaces for items and commands
`default_nettype none
interface ppbc_in_if;
  import ppbc_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [MASK_W-1:0] done_mask;
  modport source (output valid, output opcode, output done_mask, input ready);
  modport sink   (input valid, input opcode, input done_mask, output ready);
endinterface

interface ppbc_out_if;
  import ppbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] cmd_kind;
  logic [BUF_W-1:0]  buf_index;
  logic [PORT_W-1:0] port_sel;
  logic [LINE_W-1:0] first_line;
  logic [LINE_W-1:0] end_line;
  logic              last_cmd;
  modport source (output valid, output cmd_kind, output buf_index, output port_sel,
                  output first_line, output end_line, output last_cmd, input ready);
  modport sink   (input valid, input cmd_kind, input buf_index, input port_sel,
                  input first_line, input end_line, input last_cmd, output ready);
endinterface
`default_nettype wire

>>> design/ppbc_cfg_regs.sv
// apb-style configuration registers
`default_nettype none
module ppbc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppbc_pkg::PADDR_W-1:0] paddr,
  input  logic [ppbc_pkg::DATA_W-1:0]  pwdata,
  output logic [ppbc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output ppbc_pkg::cfg_t               cfg
);
  import ppbc_pkg::*;

  cfg_t              cfg_r;
  logic              wr_en;
  logic [RIDX_W-1:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.net_port       <= NET_PORT_RST;
      cfg_r.fwd_first_line <= FWD_FIRST_RST;
      cfg_r.fwd_last_line  <= FWD_LAST_RST;
      cfg_r.rev_first_line <= REV_FIRST_RST;
      cfg_r.rev_last_line  <= REV_LAST_RST;
    end else if (wr_en) begin
      unique case (ridx)
        REG_NET_PORT:  cfg_r.net_port       <= pwdata[PORT_W-1:0];
        REG_FWD_FIRST: cfg_r.fwd_first_line <= pwdata[LINE_W-1:0];
        REG_FWD_LAST:  cfg_r.fwd_last_line  <= pwdata[LINE_W-1:0];
        REG_REV_FIRST: cfg_r.rev_first_line <= pwdata[LINE_W-1:0];
        REG_REV_LAST:  cfg_r.rev_last_line  <= pwdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_NET_PORT:  prdata = DATA_W'(cfg_r.net_port);
      REG_FWD_FIRST: prdata = DATA_W'(cfg_r.fwd_first_line);
      REG_FWD_LAST:  prdata = DATA_W'(cfg_r.fwd_last_line);
      REG_REV_FIRST: prdata = DATA_W'(cfg_r.rev_first_line);
      REG_REV_LAST:  prdata = DATA_W'(cfg_r.rev_last_line);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/ppbc_front.sv
// front end: accepts items, drops empty completions, queues the rest
`default_nettype none
module ppbc_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  ppbc_in_if.sink           in_ch,
  input  logic              pop,
  output ppbc_pkg::q_head_t head
);
  import ppbc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          accept;
  logic          push;
  logic          do_pop;
  item_t         in_item;

  // classify the incoming item
  assign in_item.is_start = (in_ch.opcode == OP_START);
  assign in_item.mask     = in_ch.done_mask;

  assign in_ch.ready = (count_r != CW'(DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && (in_item.is_start || (in_item.mask != '0));
  assign do_pop      = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> design/ppbc_back.sv
// back end: buffer state, command sequencing and output register
`default_nettype none
module ppbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ppbc_pkg::cfg_t    cfg,
  input  ppbc_pkg::q_head_t head,
  output logic              pop,
  ppbc_out_if.source        out_ch
);
  import ppbc_pkg::*;

  back_state_t       state_r, state_nxt;
  phase_t            phase_r [NBUF];
  phase_t            phase_nxt [NBUF];
  logic              dsp_rx_waiting_r, dsp_rx_waiting_nxt;
  logic              net_tx_free_r, net_tx_free_nxt;
  logic              net_rx_waiting_r, net_rx_waiting_nxt;
  logic              dsp_tx_free_r, dsp_tx_free_nxt;
  logic [MASK_W-1:0] mask_r;
  logic [MASK_W-1:0] mask_rest;
  logic [BUF_W-1:0]  cur_b;
  logic              do_recv_r, do_send_r, fwd_r;
  logic [BUF_W-1:0]  recv_b_r, send_b_r;
  logic              do_recv_c, do_send_c;
  logic [BUF_W-1:0]  recv_b_c, send_b_c;
  logic              out_valid_r;
  cmd_pay_t          out_pay_r;
  cmd_pay_t          emit_pay;
  logic              can_emit;
  logic              emit;
  logic              clr_fire;

  assign can_emit  = !out_valid_r || out_ch.ready;
  assign mask_rest = mask_r & (mask_r - 1'b1);

  // lowest pending buffer
  always_comb begin
    priority if (mask_r[0]) cur_b = 2'd0;
    else if (mask_r[1])     cur_b = 2'd1;
    else if (mask_r[2])     cur_b = 2'd2;
    else                    cur_b = 2'd3;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) state_nxt = head.item.is_start ? BK_START0 : BK_CLR;
      end
      BK_START0: begin
        if (can_emit) state_nxt = BK_START1;
      end
      BK_START1: begin
        if (can_emit) state_nxt = BK_IDLE;
      end
      BK_CLR: begin
        if (can_emit) begin
          priority if (do_recv_c)    state_nxt = BK_RECV;
          else if (do_send_c)        state_nxt = BK_SEND;
          else if (mask_rest != '0)  state_nxt = BK_CLR;
          else                       state_nxt = BK_IDLE;
        end
      end
      BK_RECV: begin
        if (can_emit) begin
          priority if (do_send_r) state_nxt = BK_SEND;
          else if (mask_r != '0)  state_nxt = BK_CLR;
          else                    state_nxt = BK_IDLE;
        end
      end
      BK_SEND: begin
        if (can_emit) state_nxt = (mask_r != '0) ? BK_CLR : BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop      = 1'b0;
    emit     = 1'b0;
    clr_fire = 1'b0;
    emit_pay = '{cmd_kind: CMD_CLEAR, buf_index: '0, port_sel: '0,
                 first_line: '0, end_line: '0, last_cmd: 1'b0};
    unique case (state_r)
      BK_IDLE: begin
        pop = head.valid;
      end
      BK_START0: begin
        emit                = can_emit;
        emit_pay.cmd_kind   = CMD_RECV;
        emit_pay.buf_index  = 2'd0;
        emit_pay.port_sel   = DSP_PORT;
        emit_pay.first_line = cfg.fwd_first_line;
        emit_pay.end_line   = cfg.fwd_last_line;
      end
      BK_START1: begin
        emit                = can_emit;
        emit_pay.cmd_kind   = CMD_RECV;
        emit_pay.buf_index  = 2'd2;
        emit_pay.port_sel   = cfg.net_port;
        emit_pay.first_line = cfg.rev_first_line;
        emit_pay.end_line   = cfg.rev_last_line;
        emit_pay.last_cmd   = 1'b1;
      end
      BK_CLR: begin
        emit               = can_emit;
        clr_fire           = can_emit;
        emit_pay.buf_index = cur_b;
        emit_pay.last_cmd  = !do_recv_c && !do_send_c && (mask_rest == '0);
      end
      BK_RECV: begin
        emit                = can_emit;
        emit_pay.cmd_kind   = CMD_RECV;
        emit_pay.buf_index  = recv_b_r;
        emit_pay.port_sel   = fwd_r ? DSP_PORT : cfg.net_port;
        emit_pay.first_line = fwd_r ? cfg.fwd_first_line : cfg.rev_first_line;
        emit_pay.end_line   = fwd_r ? cfg.fwd_last_line : cfg.rev_last_line;
        emit_pay.last_cmd   = !do_send_r && (mask_r == '0);
      end
      BK_SEND: begin
        emit                = can_emit;
        emit_pay.cmd_kind   = CMD_SEND;
        emit_pay.buf_index  = send_b_r;
        emit_pay.port_sel   = fwd_r ? cfg.net_port : DSP_PORT;
        emit_pay.first_line = fwd_r ? cfg.fwd_first_line : cfg.rev_first_line;
        emit_pay.end_line   = fwd_r ? cfg.fwd_last_line : cfg.rev_last_line;
        emit_pay.last_cmd   = (mask_r == '0);
      end
      default: ;
    endcase
  end

  // buffer state update, one lane per buffer
  always_comb begin
    logic wt, fr, rc, sd, wt_n, fr_n;
    phase_nxt          = phase_r;
    dsp_rx_waiting_nxt = dsp_rx_waiting_r;
    net_tx_free_nxt    = net_tx_free_r;
    net_rx_waiting_nxt = net_rx_waiting_r;
    dsp_tx_free_nxt    = dsp_tx_free_r;
    do_recv_c          = 1'b0;
    do_send_c          = 1'b0;
    recv_b_c           = '0;
    send_b_c           = '0;
    for (int b = 0; b < NBUF; b++) begin
      wt = (b < 2) ? dsp_rx_waiting_r : net_rx_waiting_r;
      fr = (b < 2) ? net_tx_free_r : dsp_tx_free_r;
      if (phase_r[b] == PH_FILLING) begin
        // finished fill: refill partner if empty, send if transmitter free
        rc   = (phase_r[b ^ 1] == PH_EMPTY);
        sd   = fr;
        wt_n = rc ? wt : 1'b1;
        fr_n = sd ? 1'b0 : fr;
      end else begin
        // finished drain: refill if receiver waits, send partner if full
        rc   = wt;
        sd   = (phase_r[b ^ 1] == PH_FULL);
        wt_n = 1'b0;
        fr_n = sd ? fr : 1'b1;
      end
      if (cur_b == BUF_W'(b)) begin
        do_recv_c = rc;
        do_send_c = sd;
        recv_b_c  = (phase_r[b] == PH_FILLING) ? BUF_W'(b ^ 1) : BUF_W'(b);
        send_b_c  = (phase_r[b] == PH_FILLING) ? BUF_W'(b) : BUF_W'(b ^ 1);
        if (clr_fire) begin
          if (phase_r[b] == PH_FILLING) begin
            phase_nxt[b]     = sd ? PH_EMPTYING : PH_FULL;
            phase_nxt[b ^ 1] = rc ? PH_FILLING : phase_r[b ^ 1];
          end else begin
            phase_nxt[b]     = rc ? PH_FILLING : PH_EMPTY;
            phase_nxt[b ^ 1] = sd ? PH_EMPTYING : phase_r[b ^ 1];
          end
          if (b < 2) begin
            dsp_rx_waiting_nxt = wt_n;
            net_tx_free_nxt    = fr_n;
          end else begin
            net_rx_waiting_nxt = wt_n;
            dsp_tx_free_nxt    = fr_n;
          end
        end
      end
    end
    // start item reopens both receive chains
    if (pop && head.item.is_start) begin
      phase_nxt[0]       = PH_FILLING;
      phase_nxt[1]       = PH_EMPTY;
      phase_nxt[2]       = PH_FILLING;
      phase_nxt[3]       = PH_EMPTY;
      dsp_rx_waiting_nxt = 1'b0;
      net_rx_waiting_nxt = 1'b0;
      net_tx_free_nxt    = 1'b1;
      dsp_tx_free_nxt    = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= BK_IDLE;
      for (int b = 0; b < NBUF; b++) phase_r[b] <= PH_EMPTY;
      dsp_rx_waiting_r <= 1'b0;
      net_tx_free_r    <= 1'b0;
      net_rx_waiting_r <= 1'b0;
      dsp_tx_free_r    <= 1'b0;
      mask_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      phase_r          <= phase_nxt;
      dsp_rx_waiting_r <= dsp_rx_waiting_nxt;
      net_tx_free_r    <= net_tx_free_nxt;
      net_rx_waiting_r <= net_rx_waiting_nxt;
      dsp_tx_free_r    <= dsp_tx_free_nxt;
      if (pop) begin
        mask_r <= head.item.is_start ? '0 : head.item.mask;
      end else if (clr_fire) begin
        mask_r <= mask_rest;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-buffer command plan and output payload
  always_ff @(posedge clk) begin
    if (clr_fire) begin
      do_recv_r <= do_recv_c;
      do_send_r <= do_send_c;
      recv_b_r  <= recv_b_c;
      send_b_r  <= send_b_c;
      fwd_r     <= !cur_b[1];
    end
    if (emit) begin
      out_pay_r <= emit_pay;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cmd_kind   = out_pay_r.cmd_kind;
  assign out_ch.buf_index  = out_pay_r.buf_index;
  assign out_ch.port_sel   = out_pay_r.port_sel;
  assign out_ch.first_line = out_pay_r.first_line;
  assign out_ch.end_line   = out_pay_r.end_line;
  assign out_ch.last_cmd   = out_pay_r.last_cmd;

endmodule
`default_nettype wire

>>> design/ping_pong_buffer_controller_top.sv
// top level of the ping-pong buffer controller
// Controls two ping-pong buffer pairs (0/1 dsp receive to network, 2/3 network
// receive to dsp) and turns start and completion items into buffer-manager
// commands, at most one command per cycle on out_ch. The front end accepts
// one item per cycle, while the queue is not full, into a QUEUE_DEPTH-entry
// queue while the back end works; the back end picks up an item, then a start
// item gives 2 commands and a completion item gives 1 to 3 commands per set
// mask bit. A completion item with an empty mask is accepted and gives no
// command. Registers: net_port at 0x00, fwd_first_line 0x04, fwd_last_line
// 0x08, rev_first_line 0x0c, rev_last_line 0x10; write them only while no
// command is pending. QUEUE_DEPTH range 2..32.
`default_nettype none
module ping_pong_buffer_controller_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ppbc_in_if.sink                      in_ch,
  ppbc_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppbc_pkg::PADDR_W-1:0] paddr,
  input  logic [ppbc_pkg::DATA_W-1:0]  pwdata,
  output logic [ppbc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ppbc_pkg::*;

  cfg_t    cfg;
  q_head_t head;
  logic    pop;

  // configuration registers
  ppbc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // item intake and queue
  ppbc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // buffer state and command sequencer
  ppbc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> design/ppbc_checker.sv
// port-level checks for the ping-pong buffer controller, bound to the top
`default_nettype none
`include "ping_pong_buffer_controller_top_macros.svh"
module ppbc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ppbc_pkg::KIND_W-1:0] out_cmd_kind,
  input logic [ppbc_pkg::BUF_W-1:0]  out_buf_index,
  input logic [ppbc_pkg::PORT_W-1:0] out_port_sel,
  input logic [ppbc_pkg::LINE_W-1:0] out_first_line,
  input logic [ppbc_pkg::LINE_W-1:0] out_end_line,
  input logic                        out_last_cmd
);
  import ppbc_pkg::*;

  // a stalled command stays offered
  `PPBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a stalled command keeps its payload
  `PPBC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(out_cmd_kind) && $stable(out_buf_index) && $stable(out_port_sel) && $stable(out_first_line) && $stable(out_end_line) && $stable(out_last_cmd))

  // clear commands carry no port and no lines
  `PPBC_ASSERT_IMPL(a_clear_zero, out_valid && (out_cmd_kind == CMD_CLEAR),
    (out_port_sel == '0) && (out_first_line == '0) && (out_end_line == '0))

  // dsp side engines always use the dsp port
  `PPBC_ASSERT_IMPL(a_dsp_port, out_valid && (((out_cmd_kind == CMD_RECV) && !out_buf_index[1]) || ((out_cmd_kind == CMD_SEND) && out_buf_index[1])),
    out_port_sel == DSP_PORT)

endmodule

bind ping_pong_buffer_controller_top ppbc_checker u_ppbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cmd_kind   (out_ch.cmd_kind),
  .out_buf_index  (out_ch.buf_index),
  .out_port_sel   (out_ch.port_sel),
  .out_first_line (out_ch.first_line),
  .out_end_line   (out_ch.end_line),
  .out_last_cmd   (out_ch.last_cmd)
);
`default_nettype wire
